### src/gfmve_pkg.sv
package gfmve_pkg;

  // Default matrix size and the most result rows a codeword can carry.
  localparam int unsigned K_MAX_DEF    = 16;
  localparam int unsigned P_MAX_DEF    = 8;
  localparam int unsigned RESULT_LIMIT = 8;

  // Width used for counts and range compares. K_MAX and P_MAX never exceed 128.
  localparam int unsigned CNT_W = 8;

  localparam logic [8:0] GF_POLY = 9'h11B;

  localparam logic       CMD_LOAD = 1'b0;
  localparam logic       CMD_DATA = 1'b1;

  localparam logic       REG_DATA_COUNT   = 1'b0;
  localparam logic       REG_PARITY_COUNT = 1'b1;

  localparam logic [4:0] DATA_COUNT_RST   = 5'd16;
  localparam logic [3:0] PARITY_COUNT_RST = 4'd8;

  // One stage of the result chain.
  typedef struct packed {
    logic       valid;
    logic [2:0] row;
    logic [7:0] value;
    logic       last;
  } res_t;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic       rd;     // a data byte is accepted this cycle
    logic       adv;    // the multiply stage retires its byte
    logic       done;   // that byte completes the codeword
    logic       shift;  // the result at the head of the chain is taken
    logic [3:0] p_eff;  // active row count
  } ctrl_t;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] x;
    logic [7:0] acc;
    x   = a;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc = acc ^ x;
      end
      x = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY[7:0] : 8'h00);
    end
    return acc;
  endfunction

endpackage

### src/gfmve_ram.sv
module gfmve_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/gfmve_cell.sv
module gfmve_cell #(
  parameter int unsigned K_MAX = gfmve_pkg::K_MAX_DEF,
  parameter int unsigned Row   = 0,
  localparam int unsigned AddrW = (K_MAX > 1) ? $clog2(K_MAX) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gfmve_pkg::ctrl_t  ctrl_i,
  input  logic              wr_req_i,
  input  logic [2:0]        wr_row_i,
  input  logic [AddrW-1:0]  wr_addr_i,
  input  logic [7:0]        wr_data_i,
  input  logic [AddrW-1:0]  rd_addr_i,
  input  logic [7:0]        data_i,
  input  gfmve_pkg::res_t   next_i,
  output gfmve_pkg::res_t   res_o
);
  import gfmve_pkg::*;

  logic [7:0] coef;
  logic [7:0] acc_q, acc_d, acc_new;
  res_t       res_q, res_d;
  logic       active;
  logic       is_last;

  gfmve_ram #(
    .Width(8),
    .Depth(K_MAX)
  ) u_coef_ram (
    .clk_i  (clk_i),
    .we_i   (wr_req_i && (wr_row_i == 3'(Row))),
    .waddr_i(wr_addr_i),
    .wdata_i(wr_data_i),
    .re_i   (ctrl_i.rd),
    .raddr_i(rd_addr_i),
    .rdata_o(coef)
  );

  assign active  = 4'(Row) < ctrl_i.p_eff;
  assign is_last = 4'(Row + 1) == ctrl_i.p_eff;
  assign acc_new = active ? (acc_q ^ gf_mul(coef, data_i)) : acc_q;

  always_comb begin
    acc_d = acc_q;
    res_d = res_q;
    if (ctrl_i.adv) begin
      acc_d = ctrl_i.done ? 8'h00 : acc_new;
    end
    // A finished codeword loads the whole chain at once; the top level only
    // lets that happen once the chain has drained.
    if (ctrl_i.adv && ctrl_i.done) begin
      res_d.valid = active;
      res_d.row   = 3'(Row);
      res_d.value = acc_new;
      res_d.last  = is_last;
    end else if (ctrl_i.shift) begin
      res_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      res_q <= '0;
    end else begin
      acc_q <= acc_d;
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

### src/gf256_matrix_vector_erasure_encoder.sv
// GF(2^8) matrix-vector encoder.
//
// Input channel (in_valid_i / in_stall_o): a request with cmd_i low writes
// byte_value_i as the coefficient at coef_row_i, coef_col_i; a request with
// cmd_i high is the next data byte of the column. Requests are taken one per
// cycle while in_stall_o is low. The data_count-th data byte (0 counts as 1,
// capped at K_MAX) completes the codeword. Output channel (out_valid_o /
// out_stall_i): one request per active row, from row 0 up in order,
// last_flag_o set on the final one. Results follow one per cycle while the
// receiver does not stall. Results leave through a chain of row cells that
// shifts towards row 0, so a new codeword may stream in while the previous
// one drains. A completing byte is held in the multiply stage, and in_stall_o
// raised, only while the chain still holds results of the previous codeword;
// with data_count at least parity_count and no output stall the block
// sustains one data byte per cycle. Reset clears the accumulators, the
// position and the chain and sets data_count to 16 and parity_count to 8;
// coefficients must be loaded before use. Configuration must be written over
// the APB port only while the block is idle; the block does not check this.
module gf256_matrix_vector_erasure_encoder #(
  parameter int unsigned K_MAX = gfmve_pkg::K_MAX_DEF,
  parameter int unsigned P_MAX = gfmve_pkg::P_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [2:0]  coef_row_i,
  input  logic [3:0]  coef_col_i,
  input  logic [7:0]  byte_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  row_index_o,
  output logic [7:0]  parity_byte_o,
  output logic        last_flag_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gfmve_pkg::*;

  localparam int unsigned Cells = (P_MAX < RESULT_LIMIT) ? P_MAX : RESULT_LIMIT;
  localparam int unsigned PosW  = (K_MAX > 1) ? $clog2(K_MAX) : 1;

  logic [4:0]      data_count_q;
  logic [3:0]      parity_count_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic            s1_valid_q, s1_valid_d;
  logic [7:0]      s1_byte_q;
  logic            s1_last_q;

  logic [CNT_W-1:0] k_eff;
  logic [CNT_W-1:0] pos_next;
  logic [3:0]       p_eff;
  logic             accept, data_acc, load_ok, byte_last;
  logic             chain_free, hold, cfg_wr;
  ctrl_t            ctrl;
  res_t             res_a [Cells+1];

  // Active sizes: zero acts as one; counts are capped at K_MAX and Cells.
  always_comb begin
    k_eff = (data_count_q == 5'd0) ? CNT_W'(1) : CNT_W'(data_count_q);
    if (k_eff > CNT_W'(K_MAX)) begin
      k_eff = CNT_W'(K_MAX);
    end
    p_eff = (parity_count_q == 4'd0) ? 4'd1 : parity_count_q;
    if (p_eff > 4'(Cells)) begin
      p_eff = 4'(Cells);
    end
  end

  // The chain fills from row 0 upwards, so it is free next cycle when row 1
  // is empty and row 0 is empty or leaving.
  assign chain_free = !res_a[1].valid && (!res_a[0].valid || !out_stall_i);
  assign hold       = s1_valid_q && s1_last_q && !chain_free;
  assign in_stall_o = hold;
  assign accept     = in_valid_i && !in_stall_o;
  assign data_acc   = accept && (cmd_i == CMD_DATA);
  assign load_ok    = accept && (cmd_i == CMD_LOAD)
                      && (CNT_W'(coef_row_i) < CNT_W'(P_MAX))
                      && (CNT_W'(coef_col_i) < CNT_W'(K_MAX));

  assign pos_next  = CNT_W'(pos_q) + CNT_W'(1);
  assign byte_last = pos_next >= k_eff;

  always_comb begin
    pos_d      = pos_q;
    s1_valid_d = s1_valid_q;
    if (!hold) begin
      s1_valid_d = 1'b0;
    end
    if (data_acc) begin
      s1_valid_d = 1'b1;
      pos_d      = byte_last ? '0 : PosW'(pos_next);
    end
  end

  assign ctrl.rd    = data_acc;
  assign ctrl.adv   = s1_valid_q && !hold;
  assign ctrl.done  = s1_last_q;
  assign ctrl.shift = res_a[0].valid && !out_stall_i;
  assign ctrl.p_eff = p_eff;

  assign res_a[Cells] = '0;

  for (genvar r = 0; r < Cells; r++) begin : g_cell
    gfmve_cell #(
      .K_MAX(K_MAX),
      .Row  (r)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .wr_req_i (load_ok),
      .wr_row_i (coef_row_i),
      .wr_addr_i(PosW'(coef_col_i)),
      .wr_data_i(byte_value_i),
      .rd_addr_i(pos_q),
      .data_i   (s1_byte_q),
      .next_i   (res_a[r+1]),
      .res_o    (res_a[r])
    );
  end

  assign out_valid_o   = res_a[0].valid;
  assign row_index_o   = res_a[0].row;
  assign parity_byte_o = res_a[0].value;
  assign last_flag_o   = res_a[0].last;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_DATA_COUNT:   prdata = 32'(data_count_q);
      REG_PARITY_COUNT: prdata = 32'(parity_count_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_count_q   <= DATA_COUNT_RST;
      parity_count_q <= PARITY_COUNT_RST;
      pos_q          <= '0;
      s1_valid_q     <= 1'b0;
    end else begin
      if (cfg_wr && (paddr[2] == REG_DATA_COUNT)) begin
        data_count_q <= pwdata[4:0];
      end
      if (cfg_wr && (paddr[2] == REG_PARITY_COUNT)) begin
        parity_count_q <= pwdata[3:0];
      end
      pos_q      <= pos_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_acc) begin
      s1_byte_q <= byte_value_i;
      s1_last_q <= byte_last;
    end
  end

endmodule

### src/gfmve_checker.sv
module gfmve_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] row_index_o,
  input logic [7:0] parity_byte_o,
  input logic       last_flag_o
);

  // Results of one codeword come out on consecutive rows without gaps.
  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_flag_o)
    |=> (out_valid_o && (row_index_o == 3'($past(row_index_o) + 3'd1))))
    else $error("next row of a codeword missing or out of order");

  // Input is only held back while results are still waiting to leave.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i)
    |=> (out_valid_o && $stable(row_index_o) && $stable(parity_byte_o)
         && $stable(last_flag_o)))
    else $error("stalled result changed");

endmodule

bind gf256_matrix_vector_erasure_encoder gfmve_checker u_gfmve_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .row_index_o  (row_index_o),
  .parity_byte_o(parity_byte_o),
  .last_flag_o  (last_flag_o)
);
